>>> hw/rtl/lcce_pkg.sv
// ----------------------------------------------------------------------------
// lcce_pkg
// Shared types and constants of the dimmer command encoder.
// ----------------------------------------------------------------------------
`default_nettype none

package lcce_pkg;

  // configuration port
  localparam int CFG_IDX_W  = 1;
  localparam int CFG_DATA_W = 8;
  localparam logic [CFG_IDX_W-1:0] CFG_MAX_LEVEL = 1'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_DIALECT   = 1'd1;
  localparam logic [7:0] MAX_LEVEL_RST = 8'd100;

  // command queue
  localparam int QUEUE_DEPTH = 2;

  // shared divider
  localparam int DIV_NUM_W   = 28;
  localparam int DIV_DEN_W   = 25;
  localparam int DIV_CNT_W   = $clog2(DIV_NUM_W + 1);
  localparam int LEVEL_NUM_W = 16;
  localparam logic [DIV_CNT_W-1:0] LEVEL_STEPS = DIV_CNT_W'(LEVEL_NUM_W);
  localparam logic [DIV_CNT_W-1:0] RATE_STEPS  = DIV_CNT_W'(DIV_NUM_W);

  // ramp rate scaling: rate = round(d * 510000 / (239 * t))
  localparam int RATE_DEN_W = 24;
  localparam int RATE_DEN_K = 239;
  localparam int RATE_NUM_K = 1020000;
  localparam int LEVEL_PCT_K = 200;

  // command bytes
  localparam logic [7:0] BYTE_SYNC      = 8'h00;
  localparam logic [7:0] OP_SET         = 8'h03;
  localparam logic [7:0] OP_FADE        = 8'h04;
  localparam logic [7:0] BYTE_EXT       = 8'h81;
  localparam logic [7:0] BEAT_UNIT      = 8'hFF;
  localparam logic [7:0] BEAT_OP        = 8'h56;
  localparam logic [3:0] CIRC_FLAG      = 4'h8;
  localparam logic [7:0] EFF_TWINKLE    = 8'h06;
  localparam logic [7:0] EFF_SHIMMER    = 8'h07;
  localparam logic [7:0] TAIL_TWINKLE   = 8'h02;
  localparam logic [7:0] TAIL_SHIMMER   = 8'h01;
  localparam logic [7:0] LEVEL_OFF      = 8'hF0;
  localparam logic [7:0] LEVEL_FULL     = 8'h01;
  localparam logic [7:0] UNIT_LIMIT     = 8'hF0;
  localparam logic [6:0] PCT_FULL       = 7'd100;
  localparam logic [7:0] PCT_BASE       = 8'd228;
  localparam logic [31:0] BEAT_INTERVAL = 32'd300;
  localparam logic [7:0] RATE_ESC_HI    = 8'h40;
  localparam logic [7:0] RATE_ZERO_HI   = 8'h80;

  localparam int BYTE_IDX_W = 4;

  typedef enum logic [2:0] {
    REQ_SET          = 3'd0,
    REQ_RAMP         = 3'd1,
    REQ_TWINKLE      = 3'd2,
    REQ_SHIMMER      = 3'd3,
    REQ_TWINKLE_FADE = 3'd4,
    REQ_SHIMMER_FADE = 3'd5,
    REQ_TICK         = 3'd6,
    REQ_BEAT_RESET   = 3'd7
  } req_e;

  typedef enum logic [2:0] {
    CMD_SET,
    CMD_RAMP,
    CMD_EFF_SHORT,
    CMD_EFF_LONG,
    CMD_EFF_ALT,
    CMD_FADE,
    CMD_FADE_ALT,
    CMD_BEAT
  } cmd_e;

  typedef enum logic [2:0] {
    F_IDLE,
    F_DIV_MS,
    F_DIV_ME,
    F_RATE_PREP,
    F_RATE_GO,
    F_DIV_RATE,
    F_PUSH
  } front_state_e;

  typedef struct packed {
    logic [2:0]  req_type;
    logic [11:0] channel;
    logic [7:0]  start_level;
    logic [7:0]  end_level;
    logic [15:0] duration_ms;
    logic [30:0] tick_time;
  } req_t;

  typedef struct packed {
    logic [7:0] out_byte;
    logic       last_byte;
  } byte_t;

  // one queued command
  typedef struct packed {
    cmd_e       kind;
    logic [7:0] unit;
    logic [3:0] circ;
    logic       shim;
    logic [7:0] ms;
    logic [7:0] me;
    logic [7:0] hi;
    logic [7:0] lo;
  } cmd_t;

  typedef struct packed {
    logic                 start;
    logic [DIV_NUM_W-1:0] num;
    logic [DIV_DEN_W-1:0] den;
    logic [DIV_CNT_W-1:0] steps;
  } div_req_t;

  typedef struct packed {
    logic                 done;
    logic [DIV_NUM_W-1:0] quo;
  } div_rsp_t;

endpackage

`default_nettype wire

>>> hw/rtl/lcce_stream_if.sv
// ----------------------------------------------------------------------------
// lcce_stream_if
// Valid/ready channel carrying one payload per transfer.
// ----------------------------------------------------------------------------
`default_nettype none

interface lcce_stream_if #(
  parameter type payload_t = logic
) ();
  logic     valid;
  logic     ready;
  payload_t payload;

  modport source (output valid, output payload, input ready);
  modport sink (input valid, input payload, output ready);
endinterface

`default_nettype wire

>>> hw/rtl/lcce_div.sv
// ----------------------------------------------------------------------------
// lcce_div
// Restoring divider, one quotient bit per cycle; numerator left-aligned.
// ----------------------------------------------------------------------------
`default_nettype none

module lcce_div (
  input  wire logic              clk_i,
  input  wire logic              rst_ni,
  input  wire lcce_pkg::div_req_t req_i,
  output      lcce_pkg::div_rsp_t rsp_o
);
  import lcce_pkg::*;

  logic                 busy_q;
  logic                 done_q;
  logic [DIV_CNT_W-1:0] cnt_q;
  logic [DIV_DEN_W-1:0] rem_q;
  logic [DIV_DEN_W-1:0] den_q;
  logic [DIV_NUM_W-1:0] quo_q;

  logic [DIV_DEN_W:0]   shifted;
  logic [DIV_DEN_W+1:0] diff;

  assign shifted = {rem_q, quo_q[DIV_NUM_W-1]};
  assign diff    = {1'b0, shifted} - {2'b00, den_q};

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else if (req_i.start) begin
      busy_q <= 1'b1;
      done_q <= 1'b0;
      cnt_q  <= req_i.steps;
    end else if (busy_q) begin
      cnt_q <= cnt_q - 1'b1;
      if (cnt_q == DIV_CNT_W'(1)) begin
        busy_q <= 1'b0;
        done_q <= 1'b1;
      end
    end else begin
      done_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (req_i.start) begin
      rem_q <= '0;
      den_q <= req_i.den;
      quo_q <= req_i.num;
    end else if (busy_q) begin
      // remainder stays below the divisor, so the top bit is dropped
      rem_q <= diff[DIV_DEN_W+1] ? shifted[DIV_DEN_W-1:0] : diff[DIV_DEN_W-1:0];
      quo_q <= {quo_q[DIV_NUM_W-2:0], ~diff[DIV_DEN_W+1]};
    end
  end

  assign rsp_o.done = done_q;
  assign rsp_o.quo  = quo_q;

endmodule

`default_nettype wire

>>> hw/rtl/lcce_front.sv
// ----------------------------------------------------------------------------
// lcce_front
// Accepts requests, maps levels and rates, and queues one command each (none for a heartbeat reset or a tick not due).
`default_nettype none

module lcce_front (
  input  wire logic               clk_i,
  input  wire logic               rst_ni,
  input  wire logic [7:0]         max_level_i,
  input  wire logic               dialect_i,
  lcce_stream_if.sink             req_if,
  output      lcce_pkg::div_req_t div_req_o,
  input  wire lcce_pkg::div_rsp_t div_rsp_i,
  output      logic               push_valid_o,
  input  wire logic               push_ready_i,
  output      lcce_pkg::cmd_t     push_cmd_o
);
  import lcce_pkg::*;

  front_state_e state_q, state_d;

  req_t                  req_q;
  logic [7:0]            ms_q;
  logic [7:0]            me_q;
  logic [7:0]            hi_q;
  logic [7:0]            lo_q;
  logic [RATE_DEN_W-1:0] rate_den_q;
  logic [DIV_NUM_W-1:0]  rate_prod_q;
  logic                  beat_valid_q;
  logic [30:0]           beat_time_q;

  logic [7:0]  max_eff;
  logic        accept;
  req_e        in_type;
  req_e        cur_type;
  logic        beat_due;
  logic [31:0] beat_limit;
  logic [7:0]  me_new;
  logic        rate_type;
  logic [7:0]  delta;
  logic [15:0] dur_eff;
  logic [15:0] rate_sat;
  logic [7:0]  hi_raw;
  logic [7:0]  lo_raw;
  logic        full;
  logic        differ;
  logic [7:0]  unit_raw;

  function automatic logic [DIV_NUM_W-1:0] level_num(logic [7:0] lvl, logic [7:0] m);
    logic [7:0]             v;
    logic [LEVEL_NUM_W-1:0] n;
    v = (lvl > m) ? m : lvl;
    n = LEVEL_NUM_W'(v) * LEVEL_NUM_W'(LEVEL_PCT_K) + LEVEL_NUM_W'(m);
    return {n, {(DIV_NUM_W-LEVEL_NUM_W){1'b0}}};
  endfunction

  function automatic logic [7:0] map_pct(logic [6:0] p);
    logic [7:0] r;
    if (p == 7'd0) r = LEVEL_OFF;
    else if (p >= PCT_FULL) r = LEVEL_FULL;
    else r = PCT_BASE - {p, 1'b0};
    return r;
  endfunction

  assign max_eff  = (max_level_i == 8'd0) ? 8'd1 : max_level_i;
  assign accept   = req_if.valid && req_if.ready;
  assign in_type  = req_e'(req_if.payload.req_type);
  assign cur_type = req_e'(req_q.req_type);
  assign req_if.ready = (state_q == F_IDLE);

  // heartbeat when none stored, over the interval, or time went backwards
  assign beat_limit = {1'b0, beat_time_q} + BEAT_INTERVAL;
  assign beat_due   = !beat_valid_q
                   || ({1'b0, req_if.payload.tick_time} > beat_limit)
                   || (req_if.payload.tick_time < beat_time_q);

  assign me_new    = map_pct(div_rsp_i.quo[6:0]);
  assign rate_type = (cur_type == REQ_RAMP) || (cur_type == REQ_TWINKLE_FADE)
                  || (cur_type == REQ_SHIMMER_FADE);
  assign delta     = (ms_q > me_q) ? (ms_q - me_q) : (me_q - ms_q);
  assign dur_eff   = (req_q.duration_ms == 16'd0) ? 16'd1 : req_q.duration_ms;

  assign rate_sat = (|div_rsp_i.quo[DIV_NUM_W-1:16]) ? 16'hFFFF : div_rsp_i.quo[15:0];
  always_comb begin
    hi_raw = rate_sat[15:8];
    lo_raw = rate_sat[7:0];
    if (lo_raw == 8'd0) begin
      lo_raw = 8'd1;
      hi_raw = hi_raw | RATE_ESC_HI;
    end else if (hi_raw == 8'd0) begin
      hi_raw = RATE_ZERO_HI;
    end
  end

  // next state and divider control
  always_comb begin
    state_d      = state_q;
    div_req_o    = '0;
    push_valid_o = 1'b0;
    case (state_q)
      F_IDLE: begin
        if (req_if.valid) begin
          case (in_type)
            REQ_TICK: begin
              if (beat_due) state_d = F_PUSH;
            end
            REQ_BEAT_RESET: begin
              state_d = F_IDLE;
            end
            default: begin
              div_req_o.start = 1'b1;
              div_req_o.num   = level_num(req_if.payload.start_level, max_eff);
              div_req_o.den   = DIV_DEN_W'({max_eff, 1'b0});
              div_req_o.steps = LEVEL_STEPS;
              state_d         = F_DIV_MS;
            end
          endcase
        end
      end
      F_DIV_MS: begin
        if (div_rsp_i.done) begin
          div_req_o.start = 1'b1;
          div_req_o.num   = level_num(req_q.end_level, max_eff);
          div_req_o.den   = DIV_DEN_W'({max_eff, 1'b0});
          div_req_o.steps = LEVEL_STEPS;
          state_d         = F_DIV_ME;
        end
      end
      F_DIV_ME: begin
        if (div_rsp_i.done) begin
          state_d = (rate_type && (ms_q != me_new)) ? F_RATE_PREP : F_PUSH;
        end
      end
      F_RATE_PREP: begin
        state_d = F_RATE_GO;
      end
      F_RATE_GO: begin
        div_req_o.start = 1'b1;
        div_req_o.num   = rate_prod_q + DIV_NUM_W'(rate_den_q);
        div_req_o.den   = {rate_den_q, 1'b0};
        div_req_o.steps = RATE_STEPS;
        state_d         = F_DIV_RATE;
      end
      F_DIV_RATE: begin
        if (div_rsp_i.done) state_d = F_PUSH;
      end
      F_PUSH: begin
        push_valid_o = 1'b1;
        if (push_ready_i) state_d = F_IDLE;
      end
      default: begin
        state_d = F_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= F_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      beat_valid_q <= 1'b0;
    end else if (accept && (in_type == REQ_BEAT_RESET)) begin
      beat_valid_q <= 1'b0;
    end else if (accept && (in_type == REQ_TICK) && beat_due) begin
      beat_valid_q <= 1'b1;
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept && (in_type == REQ_TICK) && beat_due) beat_time_q <= req_if.payload.tick_time;
    if (accept) req_q <= req_if.payload;
    if ((state_q == F_DIV_MS) && div_rsp_i.done) ms_q <= map_pct(div_rsp_i.quo[6:0]);
    if ((state_q == F_DIV_ME) && div_rsp_i.done) me_q <= me_new;
    if (state_q == F_RATE_PREP) begin
      rate_den_q  <= RATE_DEN_W'(dur_eff) * RATE_DEN_W'(RATE_DEN_K);
      rate_prod_q <= DIV_NUM_W'(delta) * DIV_NUM_W'(RATE_NUM_K);
    end
    if ((state_q == F_DIV_RATE) && div_rsp_i.done) begin
      hi_q <= hi_raw;
      lo_q <= lo_raw;
    end
  end

  // command classification
  assign full     = req_q.start_level >= max_eff;
  assign differ   = ms_q != me_q;
  assign unit_raw = req_q.channel[11:4];

  always_comb begin
    push_cmd_o.unit = (unit_raw < UNIT_LIMIT) ? (unit_raw + 8'd1) : unit_raw;
    push_cmd_o.circ = req_q.channel[3:0];
    push_cmd_o.shim = (cur_type == REQ_SHIMMER) || (cur_type == REQ_SHIMMER_FADE);
    push_cmd_o.ms   = ms_q;
    push_cmd_o.me   = me_q;
    push_cmd_o.hi   = hi_q;
    push_cmd_o.lo   = lo_q;
    case (cur_type)
      REQ_SET: begin
        push_cmd_o.kind = CMD_SET;
      end
      REQ_RAMP: begin
        push_cmd_o.kind = differ ? CMD_RAMP : CMD_SET;
      end
      REQ_TWINKLE, REQ_SHIMMER: begin
        if (full) push_cmd_o.kind = CMD_EFF_SHORT;
        else push_cmd_o.kind = dialect_i ? CMD_EFF_ALT : CMD_EFF_LONG;
      end
      REQ_TWINKLE_FADE, REQ_SHIMMER_FADE: begin
        if (differ) push_cmd_o.kind = dialect_i ? CMD_FADE_ALT : CMD_FADE;
        else if (!dialect_i) push_cmd_o.kind = CMD_EFF_LONG;
        else push_cmd_o.kind = full ? CMD_EFF_SHORT : CMD_EFF_ALT;
      end
      default: begin
        push_cmd_o.kind = CMD_BEAT;
      end
    endcase
  end

endmodule

`default_nettype wire

>>> hw/rtl/lcce_fifo.sv
// ----------------------------------------------------------------------------
// lcce_fifo
// Short command queue between the front and back ends.
// ----------------------------------------------------------------------------
`default_nettype none

module lcce_fifo #(
  parameter int Depth = lcce_pkg::QUEUE_DEPTH
) (
  input  wire logic           clk_i,
  input  wire logic           rst_ni,
  input  wire logic           push_valid_i,
  output      logic           push_ready_o,
  input  wire lcce_pkg::cmd_t push_cmd_i,
  output      logic           pop_valid_o,
  input  wire logic           pop_ready_i,
  output      lcce_pkg::cmd_t pop_cmd_o
);
  import lcce_pkg::*;

  localparam int PtrW = $clog2(Depth);
  localparam int CntW = $clog2(Depth + 1);

  cmd_t            mem_q [Depth];
  logic [PtrW-1:0] wr_ptr_q;
  logic [PtrW-1:0] rd_ptr_q;
  logic [CntW-1:0] cnt_q;
  logic            push;
  logic            pop;

  assign push_ready_o = cnt_q < CntW'(Depth);
  assign pop_valid_o  = cnt_q != '0;
  assign pop_cmd_o    = mem_q[rd_ptr_q];
  assign push         = push_valid_i && push_ready_o;
  assign pop          = pop_valid_o && pop_ready_i;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      cnt_q    <= '0;
    end else begin
      if (push) wr_ptr_q <= (wr_ptr_q == PtrW'(Depth - 1)) ? '0 : wr_ptr_q + 1'b1;
      if (pop) rd_ptr_q <= (rd_ptr_q == PtrW'(Depth - 1)) ? '0 : rd_ptr_q + 1'b1;
      if (push && !pop) cnt_q <= cnt_q + 1'b1;
      else if (pop && !push) cnt_q <= cnt_q - 1'b1;
    end
  end

  always_ff @(posedge clk_i) begin
    if (push) mem_q[wr_ptr_q] <= push_cmd_i;
  end

endmodule

`default_nettype wire

>>> hw/rtl/lcce_back.sv
// ----------------------------------------------------------------------------
// lcce_back
// Walks a queued command and sends its bytes through an output register.
// ----------------------------------------------------------------------------
`default_nettype none

module lcce_back (
  input  wire logic           clk_i,
  input  wire logic           rst_ni,
  input  wire logic           pop_valid_i,
  output      logic           pop_ready_o,
  input  wire lcce_pkg::cmd_t pop_cmd_i,
  lcce_stream_if.source       byte_if
);
  import lcce_pkg::*;

  logic                  busy_q;
  cmd_t                  cmd_q;
  logic [BYTE_IDX_W-1:0] idx_q;
  logic                  out_valid_q;
  byte_t                 out_q;
  byte_t                 sel;
  logic                  load;

  function automatic byte_t cmd_byte(cmd_t c, logic [BYTE_IDX_W-1:0] i);
    logic [7:0]            seq [2**BYTE_IDX_W];
    logic [BYTE_IDX_W-1:0] len;
    logic [7:0]            circ;
    logic [7:0]            code;
    logic [7:0]            tail;
    byte_t                 r;
    circ = {CIRC_FLAG, c.circ};
    code = c.shim ? EFF_SHIMMER : EFF_TWINKLE;
    tail = c.shim ? TAIL_SHIMMER : TAIL_TWINKLE;
    for (int k = 0; k < 2**BYTE_IDX_W; k++) seq[k] = BYTE_SYNC;
    seq[1] = c.unit;
    case (c.kind)
      CMD_SET: begin
        seq[2] = OP_SET; seq[3] = c.ms; seq[4] = circ;
        len = BYTE_IDX_W'(6);
      end
      CMD_RAMP: begin
        seq[2] = OP_FADE; seq[3] = c.ms; seq[4] = c.me; seq[5] = c.hi;
        seq[6] = c.lo; seq[7] = circ;
        len = BYTE_IDX_W'(9);
      end
      CMD_EFF_SHORT: begin
        seq[2] = code; seq[3] = circ;
        len = BYTE_IDX_W'(5);
      end
      CMD_EFF_LONG: begin
        seq[2] = code; seq[3] = circ; seq[4] = BYTE_EXT; seq[5] = OP_SET;
        seq[6] = c.ms;
        len = BYTE_IDX_W'(8);
      end
      CMD_EFF_ALT: begin
        seq[2] = code; seq[3] = circ; seq[4] = c.ms;
        len = BYTE_IDX_W'(6);
      end
      CMD_FADE: begin
        seq[2] = code; seq[3] = circ; seq[4] = BYTE_EXT; seq[5] = OP_FADE;
        seq[6] = c.ms; seq[7] = c.me; seq[8] = c.hi; seq[9] = c.lo;
        len = BYTE_IDX_W'(11);
      end
      CMD_FADE_ALT: begin
        seq[2] = OP_FADE; seq[3] = c.ms; seq[4] = c.me; seq[5] = c.hi;
        seq[6] = c.lo; seq[7] = circ; seq[8] = tail;
        len = BYTE_IDX_W'(10);
      end
      default: begin
        // heartbeat
        seq[1] = BEAT_UNIT; seq[2] = BYTE_EXT; seq[3] = BEAT_OP;
        len = BYTE_IDX_W'(5);
      end
    endcase
    r.out_byte  = seq[i];
    r.last_byte = (i == len - 1'b1);
    return r;
  endfunction

  assign sel         = cmd_byte(cmd_q, idx_q);
  assign pop_ready_o = !busy_q;
  assign load        = busy_q && (!out_valid_q || byte_if.ready);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q      <= 1'b0;
      idx_q       <= '0;
      out_valid_q <= 1'b0;
    end else begin
      if (!busy_q && pop_valid_i) begin
        busy_q <= 1'b1;
        idx_q  <= '0;
      end else if (load) begin
        idx_q <= idx_q + 1'b1;
        if (sel.last_byte) busy_q <= 1'b0;
      end
      if (load) out_valid_q <= 1'b1;
      else if (byte_if.ready) out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (!busy_q && pop_valid_i) cmd_q <= pop_cmd_i;
    if (load) out_q <= sel;
  end

  assign byte_if.valid   = out_valid_q;
  assign byte_if.payload = out_q;

endmodule

`default_nettype wire

>>> hw/rtl/lighting_controller_command_encoder_top.sv
// ----------------------------------------------------------------------------
// lighting_controller_command_encoder_top
// Dimmer command encoder: one request in, a stream of command bytes out.
// ----------------------------------------------------------------------------
// flow: a level request is queued after two 16-step level divisions, a ramp rate after
//   one more 28-step division; a due tick goes straight to queuing, while a tick not due
//   or a heartbeat reset leaves the front idle; the front takes the next request the cycle
//   after queuing, and waits while the queue is full; bytes leave one per cycle while the
//   sink is ready, with an idle gap between commands
// reset: asynchronous, clears control state, max_level to 100, dialect to 0, no heartbeat
`default_nettype none

module lighting_controller_command_encoder_top #(
  parameter int QueueDepth = lcce_pkg::QUEUE_DEPTH
) (
  input  wire logic                            clk_i,
  input  wire logic                            rst_ni,
  input  wire logic                            cfg_we_i,
  input  wire logic [lcce_pkg::CFG_IDX_W-1:0]  cfg_idx_i,
  input  wire logic [lcce_pkg::CFG_DATA_W-1:0] cfg_data_i,
  lcce_stream_if.sink                          req_i,
  lcce_stream_if.source                        byte_o
);
  import lcce_pkg::*;

  // configuration registers; the user must write them only while idle, the block does not enforce it
  logic [7:0] max_level_q;
  logic       dialect_q;

  // divider traffic and front-to-queue, queue-to-back transfers
  div_req_t div_req;
  div_rsp_t div_rsp;
  logic     push_valid;
  logic     push_ready;
  cmd_t     push_cmd;
  logic     pop_valid;
  logic     pop_ready;
  cmd_t     pop_cmd;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      max_level_q <= MAX_LEVEL_RST;
      dialect_q   <= 1'b0;
    end else if (cfg_we_i) begin
      case (cfg_idx_i)
        CFG_MAX_LEVEL: max_level_q <= cfg_data_i[7:0];
        CFG_DIALECT:   dialect_q   <= cfg_data_i[0];
        default: begin
          max_level_q <= max_level_q;
        end
      endcase
    end
  end

  // front end: level mapping, rate computation, heartbeat timing
  lcce_front u_front (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .max_level_i  (max_level_q),
    .dialect_i    (dialect_q),
    .req_if       (req_i),
    .div_req_o    (div_req),
    .div_rsp_i    (div_rsp),
    .push_valid_o (push_valid),
    .push_ready_i (push_ready),
    .push_cmd_o   (push_cmd)
  );

  // shared divider for level percent and ramp rate
  lcce_div u_div (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .req_i  (div_req),
    .rsp_o  (div_rsp)
  );

  // decoupling queue so the byte stream can stall without blocking the front until the queue is full
  lcce_fifo #(
    .Depth (QueueDepth)
  ) u_fifo (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .push_valid_i (push_valid),
    .push_ready_o (push_ready),
    .push_cmd_i   (push_cmd),
    .pop_valid_o  (pop_valid),
    .pop_ready_i  (pop_ready),
    .pop_cmd_o    (pop_cmd)
  );

  // back end: byte sequencing with a registered output
  lcce_back u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .pop_valid_i (pop_valid),
    .pop_ready_o (pop_ready),
    .pop_cmd_i   (pop_cmd),
    .byte_if     (byte_o)
  );

endmodule

`default_nettype wire

>>> bench/tb.sv
// ----------------------------------------------------------------------------
// tb
// Self-checking bench for the dimmer command encoder: requests go in over a
// valid/ready channel, and every command byte that comes out is compared with
// a byte-level prediction kept in a small scoreboard class.
// ----------------------------------------------------------------------------
`default_nettype none

module tb;
  timeunit 1ns;
  timeprecision 1ps;

  import lcce_pkg::*;

  localparam int ITEMS_PER_PHASE = 38;
  localparam int SETTLE_CYCLES   = 120;   // above the slowest front-end pass
  localparam int HOLD_CYCLES     = 400;   // long sink hold-off
  localparam int QUIET_LIMIT     = 2000;  // cycles with no transfer at all

  // --------------------------------------------------------------------------
  // scoreboard: predicts the byte stream of each request and checks results
  // --------------------------------------------------------------------------
  class dimmer_cmd_book;
    byte_t      expected_bytes[$];
    int         mismatches;
    logic [7:0] full_scale;
    logic       alt_dialect;
    longint     beat_time;

    function new();
      full_scale  = MAX_LEVEL_RST;
      alt_dialect = 1'b0;
      beat_time   = -1;
      mismatches  = 0;
    endfunction

    // clamp, round to percent, then map onto the wire code
    function logic [7:0] level_code(logic [7:0] lvl);
      int unsigned m, v, p;
      m = (full_scale == 8'd0) ? 1 : full_scale;
      v = (lvl > m) ? m : lvl;
      p = (200 * v + m) / (2 * m);
      if (p == 0) return LEVEL_OFF;
      if (p >= 100) return LEVEL_FULL;
      return 8'(228 - 2 * p);
    endfunction

    // rounded ramp rate with saturation and the hi/lo escape rules
    function void rate_code(logic [7:0] a, logic [7:0] b, logic [15:0] dur,
                            output logic [7:0] hi, output logic [7:0] lo);
      longint unsigned d, t, den, r;
      d = (a > b) ? longint'(a) - longint'(b) : longint'(b) - longint'(a);
      t = (dur == 16'd0) ? 1 : dur;
      den = 239 * t;
      r = (2 * d * 510000 + den) / (2 * den);
      if (r > 65535) r = 65535;
      hi = 8'(r >> 8);
      lo = 8'(r);
      if (lo == 8'd0) begin
        lo = 8'd1;
        hi = hi | RATE_ESC_HI;
      end else if (hi == 8'd0) begin
        hi = RATE_ZERO_HI;
      end
    endfunction

    function void note_request(req_t r);
      logic [7:0] seq[$];
      logic [7:0] unit, circ, ms, me, hi, lo, eff, tail;
      logic       fade, full;
      req_e       kind;
      longint     t;
      byte_t      b;
      kind = req_e'(r.req_type);
      unit = r.channel[11:4];
      if (unit < UNIT_LIMIT) unit = unit + 8'd1;
      circ = {CIRC_FLAG, r.channel[3:0]};
      ms   = level_code(r.start_level);
      me   = level_code(r.end_level);
      eff  = (kind == REQ_TWINKLE || kind == REQ_TWINKLE_FADE) ? EFF_TWINKLE : EFF_SHIMMER;
      tail = (eff == EFF_TWINKLE) ? TAIL_TWINKLE : TAIL_SHIMMER;
      fade = (kind == REQ_TWINKLE_FADE || kind == REQ_SHIMMER_FADE);
      full = r.start_level >= ((full_scale == 8'd0) ? 8'd1 : full_scale);
      hi   = 8'd0;
      lo   = 8'd0;
      case (kind)
        REQ_TICK: begin
          t = r.tick_time;
          if (beat_time < 0 || t > beat_time + 300 || t < beat_time) begin
            seq = '{BYTE_SYNC, BEAT_UNIT, BYTE_EXT, BEAT_OP, BYTE_SYNC};
            beat_time = t;
          end
        end
        REQ_BEAT_RESET: begin
          beat_time = -1;
        end
        REQ_SET, REQ_RAMP: begin
          if (kind == REQ_RAMP && ms != me) begin
            rate_code(ms, me, r.duration_ms, hi, lo);
            seq = '{BYTE_SYNC, unit, OP_FADE, ms, me, hi, lo, circ, BYTE_SYNC};
          end else begin
            seq = '{BYTE_SYNC, unit, OP_SET, ms, circ, BYTE_SYNC};
          end
        end
        default: begin
          if (fade && ms != me) begin
            rate_code(ms, me, r.duration_ms, hi, lo);
            if (!alt_dialect)
              seq = '{BYTE_SYNC, unit, eff, circ, BYTE_EXT, OP_FADE, ms, me, hi, lo,
                      BYTE_SYNC};
            else
              seq = '{BYTE_SYNC, unit, OP_FADE, ms, me, hi, lo, circ, tail, BYTE_SYNC};
          end else if (!alt_dialect && (fade || !full)) begin
            seq = '{BYTE_SYNC, unit, eff, circ, BYTE_EXT, OP_SET, ms, BYTE_SYNC};
          end else if (full) begin
            seq = '{BYTE_SYNC, unit, eff, circ, BYTE_SYNC};
          end else begin
            seq = '{BYTE_SYNC, unit, eff, circ, ms, BYTE_SYNC};
          end
        end
      endcase
      foreach (seq[i]) begin
        b.out_byte  = seq[i];
        b.last_byte = (i == seq.size() - 1);
        expected_bytes = {expected_bytes, b};
      end
    endfunction

    function void check_byte(byte_t got);
      byte_t want;
      if (expected_bytes.size() == 0) begin
        $error("out_byte: nothing expected, got %h", got.out_byte);
        mismatches++;
        return;
      end
      want = expected_bytes.pop_front();
      if (got.out_byte !== want.out_byte) begin
        $error("out_byte: expected %h, got %h", want.out_byte, got.out_byte);
        mismatches++;
      end
      if (got.last_byte !== want.last_byte) begin
        $error("last_byte: expected %b, got %b", want.last_byte, got.last_byte);
        mismatches++;
      end
    endfunction
  endclass

  // --------------------------------------------------------------------------
  // clock, ports, channels and the block
  // --------------------------------------------------------------------------
  logic                  clk_i = 1'b0;
  logic                  rst_ni;
  logic                  cfg_we_i;
  logic [CFG_IDX_W-1:0]  cfg_idx_i;
  logic [CFG_DATA_W-1:0] cfg_data_i;

  lcce_stream_if #(.payload_t(req_t))  req_if ();
  lcce_stream_if #(.payload_t(byte_t)) byte_if ();

  lighting_controller_command_encoder_top u_dut (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .cfg_we_i   (cfg_we_i),
    .cfg_idx_i  (cfg_idx_i),
    .cfg_data_i (cfg_data_i),
    .req_i      (req_if),
    .byte_o     (byte_if)
  );

  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  dimmer_cmd_book book = new();

  // idling knobs, changed per phase by the stimulus process
  int unsigned send_idle_pct  = 0;
  int unsigned recv_stall_pct = 0;
  bit          squeeze_pending = 1'b0;   // asks the sink for one long hold-off
  int          quiet_cycles = 0;

  // --------------------------------------------------------------------------
  // request side helpers
  // --------------------------------------------------------------------------
  function automatic req_t mk_req(req_e k, logic [11:0] ch, logic [7:0] s, logic [7:0] e,
                                  logic [15:0] dur, logic [30:0] tt);
    req_t r;
    r.req_type    = k;
    r.channel     = ch;
    r.start_level = s;
    r.end_level   = e;
    r.duration_ms = dur;
    r.tick_time   = tt;
    return r;
  endfunction

  // extremes, the clamp edge, in-range values and any byte, the last twice as often as each other
  function automatic logic [7:0] random_level(logic [7:0] scale);
    case ($urandom_range(5))
      0:       return 8'd0;
      1:       return scale;
      2:       return 8'hFF;
      3:       return 8'($urandom_range(scale));
      default: return 8'($urandom);
    endcase
  endfunction

  function automatic req_t random_request();
    req_t        r;
    int unsigned pick;
    longint      tt;
    pick = $urandom_range(99);
    r.req_type = (pick < 12) ? REQ_SET :
                 (pick < 30) ? REQ_RAMP :
                 (pick < 40) ? REQ_TWINKLE :
                 (pick < 50) ? REQ_SHIMMER :
                 (pick < 62) ? REQ_TWINKLE_FADE :
                 (pick < 74) ? REQ_SHIMMER_FADE :
                 (pick < 94) ? REQ_TICK : REQ_BEAT_RESET;
    case ($urandom_range(9))
      0:       r.channel = 12'h000;
      1:       r.channel = 12'hFFF;
      2:       r.channel = {8'hEF, 4'($urandom)};   // unit right at the increment limit
      default: r.channel = 12'($urandom);
    endcase
    r.start_level = random_level(book.full_scale);
    // equal levels now and then, so ramps and fades fall back to the short forms
    r.end_level = ($urandom_range(4) == 0) ? r.start_level : random_level(book.full_scale);
    case ($urandom_range(6))
      0:       r.duration_ms = 16'd0;
      1:       r.duration_ms = 16'hFFFF;
      2:       r.duration_ms = 16'($urandom_range(1, 64));
      3:       r.duration_ms = 16'($urandom);
      default: r.duration_ms = 16'($urandom_range(1, 5000));
    endcase
    // tick times cluster around the stored heartbeat to hit the window edges
    tt = (book.beat_time < 0) ? 0 : book.beat_time;
    case ($urandom_range(5))
      0:       tt = tt + $urandom_range(300);
      1:       tt = tt + 301;
      2:       tt = tt - $urandom_range(1, 1000);
      3:       tt = tt + $urandom_range(301, 100000);
      default: tt = $urandom;
    endcase
    r.tick_time = 31'(tt);
    return r;
  endfunction

  // offer one request, idling at random first, and wait for its transfer
  task automatic send_req(req_t r);
    while ($urandom_range(99) < send_idle_pct) begin
      req_if.valid <= 1'b0;
      @(posedge clk_i);
    end
    req_if.valid   <= 1'b1;
    req_if.payload <= r;
    do @(posedge clk_i); while (req_if.ready !== 1'b1);
    book.note_request(r);
  endtask

  // drain every expected byte, then let a result-less request finish too
  task automatic settle();
    req_if.valid <= 1'b0;
    while (book.expected_bytes.size() != 0) @(posedge clk_i);
    repeat (SETTLE_CYCLES) @(posedge clk_i);
  endtask

  // both registers, written on back-to-back edges while the block is idle
  task automatic cfg_apply(logic [7:0] scale, logic alt);
    cfg_we_i   <= 1'b1;
    cfg_idx_i  <= CFG_MAX_LEVEL;
    cfg_data_i <= scale;
    @(posedge clk_i);
    cfg_idx_i  <= CFG_DIALECT;
    cfg_data_i <= CFG_DATA_W'(alt);
    @(posedge clk_i);
    cfg_we_i <= 1'b0;
    book.full_scale  = scale;
    book.alt_dialect = alt;
  endtask

  // --------------------------------------------------------------------------
  // byte sink: random stalls, plus one long hold-off on request
  // --------------------------------------------------------------------------
  initial begin
    int hold_left;
    hold_left = 0;
    byte_if.ready = 1'b0;
    forever begin
      @(posedge clk_i);
      if (squeeze_pending) begin
        squeeze_pending = 1'b0;
        hold_left = HOLD_CYCLES;
      end
      if (hold_left > 0) begin
        hold_left--;
        byte_if.ready <= 1'b0;
      end else begin
        byte_if.ready <= ($urandom_range(99) >= recv_stall_pct);
      end
    end
  end

  // --------------------------------------------------------------------------
  // result check and watchdog on transfers
  // --------------------------------------------------------------------------
  always @(posedge clk_i) begin
    if (rst_ni) begin
      if (byte_if.valid === 1'b1 && byte_if.ready === 1'b1)
        book.check_byte(byte_if.payload);
      if ((req_if.valid === 1'b1 && req_if.ready === 1'b1) ||
          (byte_if.valid === 1'b1 && byte_if.ready === 1'b1)) begin
        quiet_cycles <= 0;
      end else if (quiet_cycles == QUIET_LIMIT) begin
        $display("end of test: mismatches");
        $finish;
      end else begin
        quiet_cycles <= quiet_cycles + 1;
      end
    end
  end

  // --------------------------------------------------------------------------
  // stimulus
  // --------------------------------------------------------------------------
  initial begin
    logic [7:0] scale;
    logic       alt;
    rst_ni         = 1'b0;
    cfg_we_i       = 1'b0;
    cfg_idx_i      = CFG_MAX_LEVEL;
    cfg_data_i     = '0;
    req_if.valid   = 1'b0;
    req_if.payload = '0;
    repeat (4) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // directed part at reset settings: full scale 100, first dialect
    send_req(mk_req(REQ_SET, 12'h000, 8'd0, 8'd0, 16'd0, 31'd0));           // level off
    send_req(mk_req(REQ_SET, 12'hFFF, 8'hFF, 8'h00, 16'hFFFF, 31'h7FFFFFFF)); // clamped, top unit
    send_req(mk_req(REQ_SET, 12'hEF5, 8'd50, 8'd0, 16'd0, 31'd0));          // unit bumps to F0
    send_req(mk_req(REQ_RAMP, 12'h123, 8'd30, 8'd30, 16'd500, 31'd0));      // equal, set form
    send_req(mk_req(REQ_RAMP, 12'h0F0, 8'd0, 8'd100, 16'd0, 31'd0));        // zero duration, saturated
    send_req(mk_req(REQ_RAMP, 12'h0F1, 8'd100, 8'd0, 16'hFFFF, 31'd0));     // hi byte zero
    send_req(mk_req(REQ_RAMP, 12'h456, 8'd10, 8'd13, 16'd25, 31'd0));       // lo byte zero
    send_req(mk_req(REQ_RAMP, 12'h457, 8'd10, 8'd11, 16'hFFFF, 31'd0));     // rate rounds to zero
    send_req(mk_req(REQ_TWINKLE, 12'h010, 8'd100, 8'd0, 16'd0, 31'd0));     // full, short form
    send_req(mk_req(REQ_SHIMMER, 12'h011, 8'd40, 8'd0, 16'd0, 31'd0));
    send_req(mk_req(REQ_TWINKLE, 12'h012, 8'd0, 8'd0, 16'd0, 31'd0));
    send_req(mk_req(REQ_TWINKLE_FADE, 12'h020, 8'd70, 8'd70, 16'd100, 31'd0));
    send_req(mk_req(REQ_SHIMMER_FADE, 12'h021, 8'd0, 8'd255, 16'd1000, 31'd0));
    send_req(mk_req(REQ_SHIMMER_FADE, 12'h022, 8'd255, 8'd200, 16'd7, 31'd0)); // both clamp
    // heartbeat: none stored, inside the window, past it, going backwards
    send_req(mk_req(REQ_TICK, 12'h000, 8'd0, 8'd0, 16'd0, 31'd0));
    send_req(mk_req(REQ_TICK, 12'h000, 8'd0, 8'd0, 16'd0, 31'd300));
    send_req(mk_req(REQ_TICK, 12'h000, 8'd0, 8'd0, 16'd0, 31'd301));
    send_req(mk_req(REQ_TICK, 12'h000, 8'd0, 8'd0, 16'd0, 31'd100));
    send_req(mk_req(REQ_BEAT_RESET, 12'h000, 8'd0, 8'd0, 16'd0, 31'd0));
    send_req(mk_req(REQ_TICK, 12'h000, 8'd0, 8'd0, 16'd0, 31'd100));
    send_req(mk_req(REQ_TICK, 12'hFFF, 8'hFF, 8'hFF, 16'hFFFF, 31'h7FFFFFFF));
    send_req(mk_req(REQ_TICK, 12'hFFF, 8'hFF, 8'hFF, 16'hFFFF, 31'h7FFFFFFF));

    // random phases, each with its own settings and idling mix
    for (int ph = 0; ph < 5; ph++) begin
      case (ph)
        0: begin scale = 8'd255; alt = 1'b1; end
        1: begin scale = 8'd1; alt = 1'b0; end
        2: begin scale = 8'd0; alt = 1'b1; end   // zero full scale acts as one
        3: begin scale = 8'($urandom_range(2, 254)); alt = 1'($urandom_range(1)); end
        default: begin scale = MAX_LEVEL_RST; alt = 1'b1; end
      endcase
      settle();
      cfg_apply(scale, alt);
      send_idle_pct  = (ph == 1) ? 68 : (ph >= 3) ? 25 : 0;
      recv_stall_pct = (ph == 2) ? 68 : (ph >= 3) ? 25 : 0;
      for (int n = 0; n < ITEMS_PER_PHASE; n++) begin
        // sink holds off while the source keeps offering, so the queue backs up
        if (ph == 0 && n == 8) squeeze_pending = 1'b1;
        send_req(random_request());
      end
    end

    settle();
    if (book.mismatches == 0)
      $display("end of test: clean");
    else
      $display("end of test: mismatches");
    $finish;
  end

endmodule

`default_nettype wire
